// ===== rtl/core/spt_pkg.sv =====
// Shared types and constants of the swarm peer table.
`default_nettype none
package spt_pkg;

  localparam int unsigned KEY_W  = 160;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned PORT_W = 16;
  localparam int unsigned REC_W  = 49;  // {seeder, port, address}
  localparam int unsigned CNT_W  = 6;

  typedef enum logic [1:0] {
    OP_NONE      = 2'd0,
    OP_STARTED   = 2'd1,
    OP_STOPPED   = 2'd2,
    OP_COMPLETED = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STAT_OK           = 3'd0,
    STAT_PORT_ZERO    = 3'd1,
    STAT_NO_CONTENT   = 3'd2,
    STAT_CONTENT_FULL = 3'd3,
    STAT_PEER_FULL    = 3'd4,
    STAT_PEER_UNKNOWN = 3'd5
  } status_e;

endpackage
`default_nettype wire

// ===== rtl/core/swarm_peer_table.sv =====
// Swarm peer table: announce handler over content entries and their peer slots.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------------
//  in      | input     | in_valid_i / in_ready_o | operation, content key, peer key,
//          |           |                         | address, port, seeding
//  out     | output    | out_valid_o/out_ready_i | status, has_peer, address, port, last
//
// One announce at a time. The content scan reads the tag memory one entry a
// cycle, the peer scan reads the slot memory one slot a cycle, and the listing
// walks the slots again through the single read port, reading and then checking
// each slot before it reads the next. A new content entry instead sweeps its
// row. Reset clears control state only; memories need no clearing pass, since a
// content row is swept when taken. A stalled output holds the listing.
`default_nettype none
module swarm_peer_table #(
  parameter int unsigned CONTENT_ENTRIES   = 16,
  parameter int unsigned PEERS_PER_CONTENT = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  operation_i,
  input  wire logic [63:0]                 content_key_upper_i,
  input  wire logic [63:0]                 content_key_middle_i,
  input  wire logic [31:0]                 content_key_lower_i,
  input  wire logic [63:0]                 peer_key_upper_i,
  input  wire logic [63:0]                 peer_key_middle_i,
  input  wire logic [31:0]                 peer_key_lower_i,
  input  wire logic [31:0]                 peer_address_i,
  input  wire logic [15:0]                 peer_port_i,
  input  wire logic                        peer_seeding_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [2:0]                       status_o,
  output logic                             has_peer_o,
  output logic [31:0]                      listed_address_o,
  output logic [15:0]                      listed_port_o,
  output logic                             last_o
);

  localparam int unsigned CIW   = (CONTENT_ENTRIES > 1) ? $clog2(CONTENT_ENTRIES) : 1;
  localparam int unsigned PIW   = (PEERS_PER_CONTENT > 1) ? $clog2(PEERS_PER_CONTENT) : 1;
  localparam int unsigned SLOTS = CONTENT_ENTRIES * PEERS_PER_CONTENT;
  localparam int unsigned SAW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned IW    = (CIW > PIW) ? CIW : PIW;
  localparam int unsigned SCW   = IW + 1;
  localparam int unsigned KW    = spt_pkg::KEY_W;
  localparam int unsigned RW    = spt_pkg::REC_W;
  localparam int unsigned CW    = spt_pkg::CNT_W;
  localparam int unsigned SW    = 1 + KW + RW;  // {used, peer id, record}

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CSCAN = 7'b0000010,
    S_PSCAN = 7'b0000100,
    S_CLEAR = 7'b0001000,
    S_LRD   = 7'b0010000,
    S_LCHK  = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Announce being worked on.
  spt_pkg::op_e op_q;
  logic [KW-1:0] ckey_q, pkey_q;
  logic [RW-1:0] rec_q;
  logic          seed_q;

  // Scan control: issue counter and the index of the data now in the read register.
  logic [SCW-1:0] a_q, a_d;
  logic           dv_q, dv_d;
  logic [IW-1:0]  di_q, di_d;
  logic           ff_q, ff_d;
  logic [IW-1:0]  fidx_q, fidx_d;
  logic [CIW-1:0] c_q, c_d;
  spt_pkg::status_e rstat_q, rstat_d;
  logic           pend_q, pend_d;
  logic [47:0]    prec_q, prec_d;

  // Content state.
  logic [CONTENT_ENTRIES-1:0] cused_q, cused_d;
  logic [CW-1:0] seeders_q [CONTENT_ENTRIES];
  logic [CW-1:0] leechers_q [CONTENT_ENTRIES];
  logic          cnt_we;
  logic [CW-1:0] s_n, l_n;

  // Memories.
  logic [KW-1:0] cmem [CONTENT_ENTRIES];
  logic [KW-1:0] crd_q;
  logic          c_re, c_we;
  logic [CIW-1:0] c_ra, c_wa;

  logic [SW-1:0] smem [SLOTS];
  logic [SW-1:0] srd_q;
  logic          s_re, s_we;
  logic [SAW-1:0] s_ra, s_wa;
  logic [SW-1:0] s_wd;
  logic [SAW-1:0] slot_base;

  // Output register.
  logic        ovalid_q;
  logic [2:0]  ostat_q;
  logic        ohas_q, olast_q;
  logic [31:0] oaddr_q;
  logic [15:0] oport_q;
  logic        out_free, out_ld, ld_has, ld_last;
  logic [2:0]  ld_stat;
  logic [47:0] ld_rec;

  // Compare terms.
  logic [CIW-1:0] di_c;
  logic           chit, cfree, cend;
  logic           s_used, s_seed, phit, pfree, pend_scan, lqual;
  logic [KW-1:0]  s_id;
  logic [RW-1:0]  s_rec;
  logic [CW:0]    sum_cur, sum_n;
  logic [CW-1:0]  s_cur, l_cur;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !ovalid_q || out_ready_i;
  assign slot_base  = SAW'(c_q * PEERS_PER_CONTENT);

  assign di_c    = di_q[CIW-1:0];
  assign chit    = dv_q && cused_q[di_c] && (crd_q == ckey_q);
  assign cfree   = dv_q && !cused_q[di_c];
  assign cend    = dv_q && (di_q == IW'(CONTENT_ENTRIES - 1));

  assign s_used  = srd_q[SW-1];
  assign s_id    = srd_q[SW-2 -: KW];
  assign s_rec   = srd_q[RW-1:0];
  assign s_seed  = s_rec[RW-1];
  assign phit    = dv_q && s_used && (s_id == pkey_q);
  assign pfree   = dv_q && !s_used;
  assign pend_scan = dv_q && (di_q == IW'(PEERS_PER_CONTENT - 1));
  assign lqual   = s_used && !(seed_q && s_seed) && (s_id != pkey_q);

  assign s_cur   = seeders_q[c_q];
  assign l_cur   = leechers_q[c_q];
  assign sum_cur = {1'b0, s_cur} + {1'b0, l_cur};
  assign sum_n   = {1'b0, s_n} + {1'b0, l_n};

  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    dv_d    = 1'b0;
    di_d    = a_q[IW-1:0];
    ff_d    = ff_q;
    fidx_d  = fidx_q;
    c_d     = c_q;
    rstat_d = rstat_q;
    pend_d  = pend_q;
    prec_d  = prec_q;
    cused_d = cused_q;
    cnt_we  = 1'b0;
    s_n     = s_cur;
    l_n     = l_cur;
    c_re    = 1'b0;
    c_ra    = a_q[CIW-1:0];
    c_we    = 1'b0;
    c_wa    = c_q;
    s_re    = 1'b0;
    s_ra    = slot_base + SAW'(a_q[PIW-1:0]);
    s_we    = 1'b0;
    s_wa    = slot_base;
    s_wd    = {1'b1, pkey_q, rec_q};
    out_ld  = 1'b0;
    ld_stat = spt_pkg::STAT_OK;
    ld_has  = 1'b0;
    ld_last = 1'b1;
    ld_rec  = '0;

    case (state_q)
      S_IDLE: begin
        a_d  = '0;
        ff_d = 1'b0;
        if (in_valid_i) begin
          if (peer_port_i == '0) begin
            rstat_d = spt_pkg::STAT_PORT_ZERO;
            state_d = S_RESP;
          end else begin
            state_d = S_CSCAN;
          end
        end
      end

      S_CSCAN: begin
        // Issue one tag read a cycle; compare the one that came back.
        if (a_q < SCW'(CONTENT_ENTRIES)) begin
          c_re = 1'b1;
          a_d  = a_q + 1'b1;
          dv_d = 1'b1;
        end
        if (cfree && !ff_q) begin
          ff_d   = 1'b1;
          fidx_d = di_q;
        end
        if (chit) begin
          c_d     = di_c;
          a_d     = '0;
          dv_d    = 1'b0;
          ff_d    = 1'b0;
          state_d = S_PSCAN;
        end else if (cend) begin
          a_d  = '0;
          dv_d = 1'b0;
          ff_d = 1'b0;
          if (op_q != spt_pkg::OP_STARTED) begin
            rstat_d = spt_pkg::STAT_NO_CONTENT;
            state_d = S_RESP;
          end else if (ff_q || cfree) begin
            c_d     = ff_q ? fidx_q[CIW-1:0] : di_c;
            c_we    = 1'b1;
            c_wa    = ff_q ? fidx_q[CIW-1:0] : di_c;
            cused_d[ff_q ? fidx_q[CIW-1:0] : di_c] = 1'b1;
            state_d = S_CLEAR;
          end else begin
            rstat_d = spt_pkg::STAT_CONTENT_FULL;
            state_d = S_RESP;
          end
        end
      end

      S_PSCAN: begin
        if (a_q < SCW'(PEERS_PER_CONTENT)) begin
          s_re = 1'b1;
          a_d  = a_q + 1'b1;
          dv_d = 1'b1;
        end
        if (pfree && !ff_q) begin
          ff_d   = 1'b1;
          fidx_d = di_q;
        end
        if (phit || pend_scan) begin
          a_d     = '0;
          dv_d    = 1'b0;
          pend_d  = 1'b0;
          state_d = S_LRD;
          s_wa    = slot_base + SAW'(di_q[PIW-1:0]);
          if (op_q == spt_pkg::OP_STOPPED) begin
            state_d = S_RESP;
            if (phit) begin
              s_we   = 1'b1;
              s_wd   = {1'b0, pkey_q, rec_q};
              cnt_we = 1'b1;
              if (s_seed) s_n = s_cur - 1'b1;
              else        l_n = l_cur - 1'b1;
              if (sum_n == '0) cused_d[c_q] = 1'b0;
              rstat_d = spt_pkg::STAT_OK;
            end else begin
              rstat_d = spt_pkg::STAT_PEER_UNKNOWN;
            end
          end else if (phit) begin
            // Refresh the record, moving the peer between counts on a change.
            s_we   = 1'b1;
            cnt_we = 1'b1;
            if (s_seed != seed_q) begin
              if (seed_q) begin
                l_n = l_cur - 1'b1;
                s_n = s_cur + 1'b1;
              end else begin
                s_n = s_cur - 1'b1;
                l_n = l_cur + 1'b1;
              end
            end
          end else if (op_q == spt_pkg::OP_STARTED) begin
            if ((sum_cur < (CW+1)'(PEERS_PER_CONTENT)) && (ff_q || pfree)) begin
              s_we   = 1'b1;
              s_wa   = slot_base + SAW'(ff_q ? fidx_q[PIW-1:0] : di_q[PIW-1:0]);
              cnt_we = 1'b1;
              if (seed_q) s_n = s_cur + 1'b1;
              else        l_n = l_cur + 1'b1;
            end else begin
              rstat_d = spt_pkg::STAT_PEER_FULL;
              state_d = S_RESP;
            end
          end
        end
      end

      S_CLEAR: begin
        // Sweep the new row: the announcing peer in slot 0, the rest free.
        s_we = 1'b1;
        s_wa = slot_base + SAW'(a_q[PIW-1:0]);
        s_wd = (a_q == '0) ? {1'b1, pkey_q, rec_q} : {1'b0, pkey_q, rec_q};
        a_d  = a_q + 1'b1;
        if (a_q == SCW'(PEERS_PER_CONTENT - 1)) begin
          cnt_we  = 1'b1;
          s_n     = seed_q ? CW'(1) : '0;
          l_n     = seed_q ? '0 : CW'(1);
          rstat_d = spt_pkg::STAT_OK;
          state_d = S_RESP;
        end
      end

      S_LRD: begin
        if (a_q == SCW'(PEERS_PER_CONTENT)) begin
          if (pend_q) begin
            if (out_free) begin
              out_ld  = 1'b1;
              ld_has  = 1'b1;
              ld_rec  = prec_q;
              state_d = S_IDLE;
            end
          end else begin
            rstat_d = spt_pkg::STAT_OK;
            state_d = S_RESP;
          end
        end else begin
          s_re    = 1'b1;
          state_d = S_LCHK;
        end
      end

      S_LCHK: begin
        // Hold one listed peer back so the final one can carry last.
        if (!(lqual && pend_q && !out_free)) begin
          if (lqual) begin
            if (pend_q) begin
              out_ld  = 1'b1;
              ld_has  = 1'b1;
              ld_last = 1'b0;
              ld_rec  = prec_q;
            end
            pend_d = 1'b1;
            prec_d = s_rec[47:0];
          end
          a_d     = a_q + 1'b1;
          state_d = S_LRD;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_ld  = 1'b1;
          ld_stat = rstat_q;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cused_q  <= '0;
      pend_q   <= 1'b0;
      dv_q     <= 1'b0;
      ff_q     <= 1'b0;
      a_q      <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cused_q <= cused_d;
      pend_q  <= pend_d;
      dv_q    <= dv_d;
      ff_q    <= ff_d;
      a_q     <= a_d;
      if (out_ld) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    di_q    <= di_d;
    fidx_q  <= fidx_d;
    c_q     <= c_d;
    rstat_q <= rstat_d;
    prec_q  <= prec_d;
    if (in_valid_i && in_ready_o) begin
      op_q   <= spt_pkg::op_e'(operation_i);
      ckey_q <= {content_key_upper_i, content_key_middle_i, content_key_lower_i};
      pkey_q <= {peer_key_upper_i, peer_key_middle_i, peer_key_lower_i};
      seed_q <= peer_seeding_i || (operation_i == spt_pkg::OP_COMPLETED);
      rec_q  <= {peer_seeding_i || (operation_i == spt_pkg::OP_COMPLETED),
                 peer_port_i, peer_address_i};
    end
    if (cnt_we) begin
      seeders_q[c_q]  <= s_n;
      leechers_q[c_q] <= l_n;
    end
    if (out_ld) begin
      ostat_q <= ld_stat;
      ohas_q  <= ld_has;
      olast_q <= ld_last;
      oaddr_q <= ld_rec[31:0];
      oport_q <= ld_rec[47:32];
    end
  end

  // Content tag memory.
  always_ff @(posedge clk_i) begin
    if (c_we) cmem[c_wa] <= ckey_q;
    if (c_re) crd_q <= cmem[c_ra];
  end

  // Peer slot memory.
  always_ff @(posedge clk_i) begin
    if (s_we) smem[s_wa] <= s_wd;
    if (s_re) srd_q <= smem[s_ra];
  end

  assign out_valid_o      = ovalid_q;
  assign status_o         = ostat_q;
  assign has_peer_o       = ohas_q;
  assign listed_address_o = oaddr_q;
  assign listed_port_o    = oport_q;
  assign last_o           = olast_q;

endmodule
`default_nettype wire

// ===== rtl/core/spt_checker.sv =====
// Port-level checks of the swarm peer table and their binding.
`default_nettype none
module spt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [2:0]  status_o,
  input wire logic        has_peer_o,
  input wire logic [31:0] listed_address_o,
  input wire logic [15:0] listed_port_o,
  input wire logic        last_o
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(listed_address_o) && $stable(listed_port_o) && $stable(last_o))
    else $error("stalled result changed");

  a_peer_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_peer_o |-> status_o == spt_pkg::STAT_OK)
    else $error("listed peer with error status");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_peer_o |-> last_o)
    else $error("peerless result not last");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second announce taken at once");

endmodule

bind swarm_peer_table spt_checker u_spt_checker (.*);
`default_nettype wire

// ===== dv/swarm_peer_table_checker.sv =====
// Checker for the swarm peer table: predicts announce results and compares them.
`timescale 1ns / 1ps
module swarm_peer_table_checker #(
  parameter int unsigned CONTENT_ENTRIES   = 16,
  parameter int unsigned PEERS_PER_CONTENT = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [1:0]  operation_i,
  input  wire logic [63:0] content_key_upper_i,
  input  wire logic [63:0] content_key_middle_i,
  input  wire logic [31:0] content_key_lower_i,
  input  wire logic [63:0] peer_key_upper_i,
  input  wire logic [63:0] peer_key_middle_i,
  input  wire logic [31:0] peer_key_lower_i,
  input  wire logic [31:0] peer_address_i,
  input  wire logic [15:0] peer_port_i,
  input  wire logic        peer_seeding_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [2:0]  status_i,
  input  wire logic        has_peer_i,
  input  wire logic [31:0] listed_address_i,
  input  wire logic [15:0] listed_port_i,
  input  wire logic        last_i,
  output int               errors_o,
  output int               pending_o
);

  localparam int unsigned SLOTS = CONTENT_ENTRIES * PEERS_PER_CONTENT;
  localparam int unsigned KW    = spt_pkg::KEY_W;
  localparam int unsigned RW    = spt_pkg::REC_W;
  localparam int unsigned CW    = spt_pkg::CNT_W;

  typedef struct packed {
    spt_pkg::status_e status;
    logic             has_peer;
    logic [31:0]      address;
    logic [15:0]      port;
    logic             last;
  } answer_t;

  answer_t answer_q[$];

  logic            row_used [CONTENT_ENTRIES];
  logic [KW-1:0]   row_key  [CONTENT_ENTRIES];
  logic [CW-1:0]   seeders  [CONTENT_ENTRIES];
  logic [CW-1:0]   leechers [CONTENT_ENTRIES];
  int unsigned     rows_taken;
  logic            peer_used[SLOTS];
  logic [KW-1:0]   peer_id  [SLOTS];
  logic [RW-1:0]   peer_rec [SLOTS];

  assign pending_o = answer_q.size();

  function automatic answer_t single(spt_pkg::status_e st);
    answer_t a;
    a = '{status: st, has_peer: 1'b0, address: '0, port: '0, last: 1'b1};
    return a;
  endfunction

  function automatic int find_row(logic [KW-1:0] key);
    for (int c = 0; c < CONTENT_ENTRIES; c++)
      if (row_used[c] && row_key[c] == key) return c;
    return -1;
  endfunction

  function automatic int find_slot(int c, logic [KW-1:0] id);
    int s;
    for (int i = 0; i < PEERS_PER_CONTENT; i++) begin
      s = c * PEERS_PER_CONTENT + i;
      if (peer_used[s] && peer_id[s] == id) return s;
    end
    return -1;
  endfunction

  // move a known peer between counts and refresh its record
  function automatic void refresh_peer(int c, int s, logic [RW-1:0] rec);
    if (peer_rec[s][48] != rec[48]) begin
      if (rec[48]) begin
        leechers[c] -= 1'b1;
        seeders[c]  += 1'b1;
      end else begin
        seeders[c]  -= 1'b1;
        leechers[c] += 1'b1;
      end
    end
    peer_rec[s] = rec;
  endfunction

  function automatic void predict_announce(spt_pkg::op_e op, logic [KW-1:0] key,
      logic [KW-1:0] id, logic [31:0] addr, logic [15:0] port, logic seed_in);
    logic          seed;
    logic [RW-1:0] rec;
    int            c, s, t, n;
    answer_t       a;
    seed = seed_in | (op == spt_pkg::OP_COMPLETED);
    rec  = {seed, port, addr};
    if (port == '0) begin
      answer_q.push_back(single(spt_pkg::STAT_PORT_ZERO));
      return;
    end
    c = find_row(key);
    if (op != spt_pkg::OP_STARTED && c < 0) begin
      answer_q.push_back(single(spt_pkg::STAT_NO_CONTENT));
      return;
    end
    if (op == spt_pkg::OP_STARTED) begin
      if (c < 0) begin
        if (rows_taken < CONTENT_ENTRIES)
          for (int i = 0; i < CONTENT_ENTRIES && c < 0; i++)
            if (!row_used[i]) c = i;
        if (c < 0) begin
          answer_q.push_back(single(spt_pkg::STAT_CONTENT_FULL));
          return;
        end
        row_used[c] = 1'b1;
        row_key[c]  = key;
        seeders[c]  = '0;
        leechers[c] = '0;
        for (int i = 0; i < PEERS_PER_CONTENT; i++)
          peer_used[c * PEERS_PER_CONTENT + i] = 1'b0;
        rows_taken++;
      end
      s = find_slot(c, id);
      if (s >= 0) begin
        refresh_peer(c, s, rec);
      end else begin
        if (int'(seeders[c]) + int'(leechers[c]) < PEERS_PER_CONTENT)
          for (int i = 0; i < PEERS_PER_CONTENT && s < 0; i++)
            if (!peer_used[c * PEERS_PER_CONTENT + i]) s = c * PEERS_PER_CONTENT + i;
        if (s < 0) begin
          answer_q.push_back(single(spt_pkg::STAT_PEER_FULL));
          return;
        end
        peer_used[s] = 1'b1;
        peer_id[s]   = id;
        peer_rec[s]  = rec;
        if (seed) seeders[c] += 1'b1;
        else leechers[c] += 1'b1;
      end
    end else if (op == spt_pkg::OP_STOPPED) begin
      s = find_slot(c, id);
      if (s < 0) begin
        answer_q.push_back(single(spt_pkg::STAT_PEER_UNKNOWN));
        return;
      end
      peer_used[s] = 1'b0;
      if (peer_rec[s][48]) seeders[c] -= 1'b1;
      else leechers[c] -= 1'b1;
      if (int'(seeders[c]) + int'(leechers[c]) == 0) begin
        row_used[c] = 1'b0;
        if (rows_taken > 0) rows_taken--;
      end
      answer_q.push_back(single(spt_pkg::STAT_OK));
      return;
    end else begin
      s = find_slot(c, id);
      if (s >= 0) refresh_peer(c, s, rec);
    end
    // list the other peers; seeders are hidden from a seeding asker
    n = 0;
    for (int i = 0; i < PEERS_PER_CONTENT; i++) begin
      t = c * PEERS_PER_CONTENT + i;
      if (!peer_used[t] || (seed && peer_rec[t][48]) || peer_id[t] == id) continue;
      a = '{status: spt_pkg::STAT_OK, has_peer: 1'b1, address: peer_rec[t][31:0],
            port: peer_rec[t][47:32], last: 1'b0};
      answer_q.push_back(a);
      n++;
    end
    if (n == 0) answer_q.push_back(single(spt_pkg::STAT_OK));
    else answer_q[$].last = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      errors_o   <= 0;
      rows_taken = 0;
      answer_q.delete();
      for (int c = 0; c < CONTENT_ENTRIES; c++) row_used[c] = 1'b0;
      for (int s = 0; s < SLOTS; s++) peer_used[s] = 1'b0;
    end else begin
      if (in_valid_i && in_ready_i)
        predict_announce(spt_pkg::op_e'(operation_i),
                         {content_key_upper_i, content_key_middle_i, content_key_lower_i},
                         {peer_key_upper_i, peer_key_middle_i, peer_key_lower_i},
                         peer_address_i, peer_port_i, peer_seeding_i);
      if (out_valid_i && out_ready_i) begin
        if (answer_q.size() == 0) begin
          if (errors_o < 10)
            $display("unexpected result at %0t: st=%0d hp=%0b a=%h p=%h l=%0b",
                     $time, status_i, has_peer_i, listed_address_i, listed_port_i,
                     last_i);
          errors_o <= errors_o + 1;
        end else begin
          want = answer_q.pop_front();
          if (want.status != status_i || want.has_peer != has_peer_i ||
              want.address != listed_address_i || want.port != listed_port_i ||
              want.last != last_i) begin
            if (errors_o < 10)
              $display({"mismatch at %0t: want st=%0d hp=%0b a=%h p=%h l=%0b,",
                        " got st=%0d hp=%0b a=%h p=%h l=%0b"},
                       $time, want.status, want.has_peer, want.address, want.port,
                       want.last, status_i, has_peer_i, listed_address_i,
                       listed_port_i, last_i);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== dv/swarm_peer_table_tb.sv =====
// Testbench top for the swarm peer table: stimulus, stalls and the verdict.
`timescale 1ns / 1ps
module swarm_peer_table_tb;

  localparam int LIMIT = 2_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  operation_i = '0;
  logic [63:0] content_key_upper_i = '0, content_key_middle_i = '0;
  logic [31:0] content_key_lower_i = '0;
  logic [63:0] peer_key_upper_i = '0, peer_key_middle_i = '0;
  logic [31:0] peer_key_lower_i = '0;
  logic [31:0] peer_address_i = '0;
  logic [15:0] peer_port_i = '0;
  logic        peer_seeding_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic        has_peer_o;
  logic [31:0] listed_address_o;
  logic [15:0] listed_port_o;
  logic        last_o;
  int          errors, pending;
  int          cycles = 0;
  int          gap_left = 0;

  // small pools of keys so announces hit the same swarms and peers again
  logic [159:0] content_pool[20];
  logic [159:0] peer_pool[40];

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  swarm_peer_table dut (.*);

  swarm_peer_table_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .operation_i,
    .content_key_upper_i, .content_key_middle_i, .content_key_lower_i,
    .peer_key_upper_i, .peer_key_middle_i, .peer_key_lower_i,
    .peer_address_i, .peer_port_i, .peer_seeding_i,
    .out_valid_i(out_valid_o), .out_ready_i, .status_i(status_o),
    .has_peer_i(has_peer_o), .listed_address_i(listed_address_o),
    .listed_port_i(listed_port_o), .last_i(last_o),
    .errors_o(errors), .pending_o(pending)
  );

  // receiver stalls: quiet stretches, then phases of random back-pressure
  always @(negedge clk_i) begin
    if ((cycles / 700) % 3 == 0) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(0, 99) < 60);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // present one announce at the falling edge and hold it until accepted;
  // valid stays up into the next announce and drops only for a gap
  task automatic announce(spt_pkg::op_e op, logic [159:0] key, logic [159:0] id,
                          logic [31:0] addr, logic [15:0] port, logic seed);
    int gap;
    if (gap_left == 0) begin
      gap = $urandom_range(0, 1) ? 0 : int'($urandom_range(1, 30));
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      gap_left = $urandom_range(1, 12);
    end
    gap_left--;
    in_valid_i          <= 1'b1;
    operation_i         <= op;
    {content_key_upper_i, content_key_middle_i, content_key_lower_i} <= key;
    {peer_key_upper_i, peer_key_middle_i, peer_key_lower_i}          <= id;
    peer_address_i      <= addr;
    peer_port_i         <= port;
    peer_seeding_i      <= seed;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [159:0] wide_random();
    return {$urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  initial begin
    logic [159:0] k;
    int           roll;
    spt_pkg::op_e op_pick;
    foreach (content_pool[i]) content_pool[i] = wide_random();
    foreach (peer_pool[i]) peer_pool[i] = wide_random();
    content_pool[0] = '0;
    content_pool[1] = '1;
    peer_pool[0] = '0;
    peer_pool[1] = '1;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: error cases, then a swarm built up and taken apart
    announce(spt_pkg::OP_STARTED, content_pool[0], peer_pool[0], '0, '0, 1'b0);
    announce(spt_pkg::OP_NONE, content_pool[0], peer_pool[0], 32'h0a000001, 16'h1, 1'b0);
    announce(spt_pkg::OP_STOPPED, content_pool[0], peer_pool[0], '1, '1, 1'b0);
    announce(spt_pkg::OP_COMPLETED, content_pool[0], peer_pool[0], '1, '1, 1'b0);
    announce(spt_pkg::OP_STARTED, content_pool[0], peer_pool[0], '0, 16'h1, 1'b0);
    announce(spt_pkg::OP_STARTED, content_pool[0], peer_pool[1], '1, '1, 1'b1);
    announce(spt_pkg::OP_STARTED, content_pool[0], peer_pool[2], 32'h55aa55aa, 16'h8000,
             1'b0);
    announce(spt_pkg::OP_NONE, content_pool[0], peer_pool[0], 32'h12345678, 16'h1234, 1'b1);
    announce(spt_pkg::OP_NONE, content_pool[0], peer_pool[5], 32'h1, 16'h2, 1'b0);
    announce(spt_pkg::OP_STARTED, content_pool[0], peer_pool[2], 32'h1, 16'h7, 1'b1);
    announce(spt_pkg::OP_COMPLETED, content_pool[0], peer_pool[0], 32'h2, 16'h3, 1'b0);
    announce(spt_pkg::OP_STOPPED, content_pool[0], peer_pool[9], 32'h2, 16'h3, 1'b0);
    announce(spt_pkg::OP_STOPPED, content_pool[0], peer_pool[0], 32'h2, 16'h3, 1'b0);
    announce(spt_pkg::OP_STOPPED, content_pool[0], peer_pool[1], 32'h2, 16'h3, 1'b0);
    announce(spt_pkg::OP_STOPPED, content_pool[0], peer_pool[2], 32'h2, 16'h3, 1'b0);
    announce(spt_pkg::OP_NONE, content_pool[0], peer_pool[2], 32'h2, 16'h3, 1'b0);
    // fill one swarm past its peer limit
    for (int i = 0; i < 33; i++)
      announce(spt_pkg::OP_STARTED, content_pool[1], wide_random(), $urandom,
               16'($urandom_range(1, 65535)), 1'($urandom_range(0, 1)));
    announce(spt_pkg::OP_NONE, content_pool[1], peer_pool[3], 32'h3, 16'h4, 1'b0);
    // fill the content table past its limit
    for (int i = 0; i < 16; i++)
      announce(spt_pkg::OP_STARTED, wide_random(), peer_pool[4], $urandom, 16'hffff, 1'b0);

    // random: mostly well-formed traffic over the pools, some noise
    for (int n = 0; n < 164; n++) begin
      roll = $urandom_range(0, 99);
      k = (roll < 5) ? wide_random() : content_pool[$urandom_range(0, 19)];
      op_pick = ($urandom_range(0, 99) < 40) ? spt_pkg::OP_STARTED
                                             : spt_pkg::op_e'(2'($urandom_range(0, 3)));
      announce(op_pick, k,
               ($urandom_range(0, 99) < 5) ? wide_random() : peer_pool[$urandom_range(0, 39)],
               $urandom, ($urandom_range(0, 99) < 4) ? 16'h0 : 16'($urandom),
               1'($urandom_range(0, 1)));
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
